FILE: design/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types and codes for the serial frame receiver and classifier.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] START_BYTE   = 8'hfc;
  localparam logic [BYTE_W-1:0] TYPE_INFO    = 8'h62;
  localparam logic [BYTE_W-1:0] TYPE_UPDATE  = 8'h61;
  localparam logic [BYTE_W-1:0] TYPE_CONNECT = 8'h7a;
  localparam logic [BYTE_W-1:0] FUNC_LEN     = 8'h10;
  localparam logic [BYTE_W-1:0] INFO_SETTING = 8'h02;
  localparam logic [BYTE_W-1:0] INFO_ROOM    = 8'h03;
  localparam logic [BYTE_W-1:0] INFO_TIMER   = 8'h05;
  localparam logic [BYTE_W-1:0] INFO_STATUS  = 8'h06;
  localparam logic [BYTE_W-1:0] INFO_FUNC_A  = 8'h20;
  localparam logic [BYTE_W-1:0] INFO_FUNC_B  = 8'h22;

  localparam logic [BYTE_W-1:0] HDR_POS_TYPE = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_POS_B2   = 8'd2;
  localparam logic [BYTE_W-1:0] HDR_POS_B3   = 8'd3;

  localparam logic [BYTE_W-1:0] RST_EXPECT_B2 = 8'd1;
  localparam logic [BYTE_W-1:0] RST_EXPECT_B3 = 8'd48;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECT_B2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECT_B3 = 1'b1;

  typedef enum logic [2:0] {
    OC_FAIL     = 3'd0,
    OC_SETTINGS = 3'd1,
    OC_ROOM     = 3'd2,
    OC_TIMER    = 3'd3,
    OC_STATUS   = 3'd4,
    OC_FUNCS    = 3'd5,
    OC_UPDATE   = 3'd6,
    OC_CONNECT  = 3'd7
  } outcome_t;

  typedef enum logic [1:0] {
    FC_NONE      = 2'd0,
    FC_HEADER    = 2'd1,
    FC_CHECKSUM  = 2'd2,
    FC_UNHANDLED = 2'd3
  } cause_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef struct packed {
    outcome_t          outcome;
    cause_t            fail_cause;
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] info_code;
    logic [BYTE_W-1:0] payload_len;
    logic              link_up;
  } result_t;

endpackage

FILE: design/sfrc_parser.sv
// ----------------------------------------------------------------------------
// sfrc_parser
// Frame state machine: hunts for the start byte, checks the header, counts
// data bytes, sums for the checksum and classifies each finished frame.
// ----------------------------------------------------------------------------
module sfrc_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [sfrc_pkg::BYTE_W-1:0] rx_byte,
  input  logic [sfrc_pkg::BYTE_W-1:0] expect_b2,
  input  logic [sfrc_pkg::BYTE_W-1:0] expect_b3,
  output logic                        res_valid,
  output sfrc_pkg::result_t           res
);

  sfrc_pkg::phase_t            phase, phase_next;
  logic [sfrc_pkg::BYTE_W-1:0] byte_count, byte_count_next;
  logic [sfrc_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [sfrc_pkg::BYTE_W-1:0] type_byte, type_byte_next;
  logic [sfrc_pkg::BYTE_W-1:0] length_byte, length_byte_next;
  logic [sfrc_pkg::BYTE_W-1:0] first_data, first_data_next;
  logic                        header_ok, header_ok_next;
  logic                        connected, connected_next;

  logic [sfrc_pkg::BYTE_W-1:0] sum_add;
  logic [sfrc_pkg::BYTE_W-1:0] fd_eff;
  logic                        at_checksum;
  logic                        sum_ok;
  sfrc_pkg::outcome_t          cls;

  function automatic sfrc_pkg::outcome_t classify(
    input logic [sfrc_pkg::BYTE_W-1:0] t,
    input logic [sfrc_pkg::BYTE_W-1:0] fd,
    input logic [sfrc_pkg::BYTE_W-1:0] len
  );
    sfrc_pkg::outcome_t oc;
    oc = sfrc_pkg::OC_FAIL;
    if (t == sfrc_pkg::TYPE_INFO) begin
      if (fd == sfrc_pkg::INFO_SETTING) oc = sfrc_pkg::OC_SETTINGS;
      else if (fd == sfrc_pkg::INFO_ROOM) oc = sfrc_pkg::OC_ROOM;
      else if (fd == sfrc_pkg::INFO_TIMER) oc = sfrc_pkg::OC_TIMER;
      else if (fd == sfrc_pkg::INFO_STATUS) oc = sfrc_pkg::OC_STATUS;
      else if ((fd == sfrc_pkg::INFO_FUNC_A || fd == sfrc_pkg::INFO_FUNC_B) &&
               len == sfrc_pkg::FUNC_LEN) oc = sfrc_pkg::OC_FUNCS;
    end else if (t == sfrc_pkg::TYPE_UPDATE) begin
      oc = sfrc_pkg::OC_UPDATE;
    end else if (t == sfrc_pkg::TYPE_CONNECT) begin
      oc = sfrc_pkg::OC_CONNECT;
    end
    return oc;
  endfunction

  assign sum_add     = running_sum + rx_byte;
  assign at_checksum = (byte_count >= length_byte);
  assign fd_eff      = (length_byte == '0) ? rx_byte : first_data;
  assign sum_ok      = (rx_byte == sfrc_pkg::BYTE_W'(sfrc_pkg::START_BYTE - running_sum));
  assign cls         = classify(type_byte, fd_eff, length_byte);

  // next state
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    type_byte_next   = type_byte;
    length_byte_next = length_byte;
    first_data_next  = first_data;
    header_ok_next   = header_ok;
    connected_next   = connected;
    unique case (phase)
      sfrc_pkg::PH_HEADER: begin
        running_sum_next = sum_add;
        byte_count_next  = byte_count + 8'd1;
        priority if (byte_count == sfrc_pkg::HDR_POS_TYPE) begin
          type_byte_next = rx_byte;
        end else if (byte_count == sfrc_pkg::HDR_POS_B2) begin
          header_ok_next = (rx_byte == expect_b2);
        end else if (byte_count == sfrc_pkg::HDR_POS_B3) begin
          header_ok_next = header_ok && (rx_byte == expect_b3);
        end else begin
          length_byte_next = rx_byte;
          byte_count_next  = '0;
          if (!header_ok) begin
            phase_next     = sfrc_pkg::PH_HUNT;
            header_ok_next = 1'b1;
          end else begin
            phase_next      = sfrc_pkg::PH_DATA;
            first_data_next = '0;
          end
        end
      end
      sfrc_pkg::PH_DATA: begin
        if (!at_checksum) begin
          if (byte_count == '0) first_data_next = rx_byte;
          running_sum_next = sum_add;
          byte_count_next  = byte_count + 8'd1;
        end else begin
          first_data_next = fd_eff;
          phase_next      = sfrc_pkg::PH_HUNT;
          byte_count_next = '0;
          header_ok_next  = 1'b1;
          if (sum_ok && cls == sfrc_pkg::OC_CONNECT) connected_next = 1'b1;
        end
      end
      default: begin
        if (rx_byte == sfrc_pkg::START_BYTE) begin
          phase_next       = sfrc_pkg::PH_HEADER;
          byte_count_next  = 8'd1;
          running_sum_next = sfrc_pkg::START_BYTE;
          header_ok_next   = 1'b1;
        end else begin
          phase_next = sfrc_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_valid       = 1'b0;
    res.outcome     = sfrc_pkg::OC_FAIL;
    res.fail_cause  = sfrc_pkg::FC_NONE;
    res.msg_type    = type_byte;
    res.info_code   = fd_eff;
    res.payload_len = length_byte;
    res.link_up     = connected;
    unique case (phase)
      sfrc_pkg::PH_HEADER: begin
        if (byte_count != sfrc_pkg::HDR_POS_TYPE && byte_count != sfrc_pkg::HDR_POS_B2 &&
            byte_count != sfrc_pkg::HDR_POS_B3 && !header_ok) begin
          res_valid       = 1'b1;
          res.fail_cause  = sfrc_pkg::FC_HEADER;
          res.info_code   = '0;
          res.payload_len = rx_byte;
        end
      end
      sfrc_pkg::PH_DATA: begin
        if (at_checksum) begin
          res_valid = 1'b1;
          if (!sum_ok) begin
            res.fail_cause = sfrc_pkg::FC_CHECKSUM;
          end else begin
            res.outcome    = cls;
            res.fail_cause = (cls == sfrc_pkg::OC_FAIL) ? sfrc_pkg::FC_UNHANDLED
                                                         : sfrc_pkg::FC_NONE;
            res.link_up    = connected || (cls == sfrc_pkg::OC_CONNECT);
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfrc_pkg::PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      type_byte   <= '0;
      length_byte <= '0;
      first_data  <= '0;
      header_ok   <= 1'b1;
      connected   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      type_byte   <= type_byte_next;
      length_byte <= length_byte_next;
      first_data  <= first_data_next;
      header_ok   <= header_ok_next;
      connected   <= connected_next;
    end
  end

endmodule

FILE: design/sfrc_out_reg.sv
// ----------------------------------------------------------------------------
// sfrc_out_reg
// Result register: holds one finished frame report until it is taken.
// ----------------------------------------------------------------------------
module sfrc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sfrc_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              room,
  output sfrc_pkg::result_t res_q
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

FILE: design/serial_frame_receiver_classifier.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_classifier
// Splits received bytes into frames and reports one outcome per frame.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    rx_byte
//  out      out_valid/out_ready  outcome fail_cause msg_type info_code
//                                payload_len link_up
//  cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
//  one byte is taken per cycle while in_ready is high; its report, if any, is in
//  the result register on the next cycle
//  in_ready drops only while a report waits and out_ready is low
//  cfg_ready is always high; synchronous reset restores both expected
//  header bytes and returns the parser to hunting
// ----------------------------------------------------------------------------
module serial_frame_receiver_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfrc_pkg::BYTE_W-1:0]    rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     outcome,
  output logic [1:0]                     fail_cause,
  output logic [sfrc_pkg::BYTE_W-1:0]    msg_type,
  output logic [sfrc_pkg::BYTE_W-1:0]    info_code,
  output logic [sfrc_pkg::BYTE_W-1:0]    payload_len,
  output logic                           link_up,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfrc_pkg::BYTE_W-1:0]    cfg_data
);

  logic [sfrc_pkg::BYTE_W-1:0] expect_b2;
  logic [sfrc_pkg::BYTE_W-1:0] expect_b3;
  logic                        in_accept;
  logic                        res_valid;
  sfrc_pkg::result_t           res;
  sfrc_pkg::result_t           res_q;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_b2 <= sfrc_pkg::RST_EXPECT_B2;
      expect_b3 <= sfrc_pkg::RST_EXPECT_B3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfrc_pkg::REG_EXPECT_B2: expect_b2 <= cfg_data;
        sfrc_pkg::REG_EXPECT_B3: expect_b3 <= cfg_data;
      endcase
    end
  end

  sfrc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .rx_byte   (rx_byte),
    .expect_b2 (expect_b2),
    .expect_b3 (expect_b3),
    .res_valid (res_valid),
    .res       (res)
  );

  sfrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .room      (in_ready),
    .res_q     (res_q)
  );

  assign outcome     = res_q.outcome;
  assign fail_cause  = res_q.fail_cause;
  assign msg_type    = res_q.msg_type;
  assign info_code   = res_q.info_code;
  assign payload_len = res_q.payload_len;
  assign link_up     = res_q.link_up;

`ifndef SYNTHESIS
  a_fail_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((outcome == sfrc_pkg::OC_FAIL) == (fail_cause != sfrc_pkg::FC_NONE)))
    else $error("outcome and fail cause disagree");

  a_connect_link: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == sfrc_pkg::OC_CONNECT |-> link_up)
    else $error("connect report without link flag");

  a_header_info: assert property (@(posedge clk) disable iff (rst)
    out_valid && fail_cause == sfrc_pkg::FC_HEADER |-> info_code == '0)
    else $error("header mismatch report with nonzero info");

  a_funcs_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == sfrc_pkg::OC_FUNCS |-> payload_len == sfrc_pkg::FUNC_LEN)
    else $error("functions report with wrong length");
`endif

endmodule
